>>> src/bbr_pkg.sv
// shared types, constants and a helper function for the 3x3 rgb box blur
package bbr_pkg;

  // frame limits
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 4096;

  // field and counter widths
  localparam int unsigned WidthW  = 11;
  localparam int unsigned HeightW = 13;
  localparam int unsigned ColW    = $clog2(MaxWidth);
  localparam int unsigned RowW    = 13;
  localparam int unsigned OrowW   = 12;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned PixW    = 3 * ChanW;
  localparam int unsigned LineW   = 2 * PixW;
  localparam int unsigned SumW    = 12;
  localparam int unsigned CntW    = 4;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 13;

  // reciprocal multiply for the rounded mean
  localparam int unsigned RecipW     = 25;
  localparam int unsigned RecipShift = 24;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 1'b1;

  // register reset values
  localparam logic [WidthW-1:0]  FrameWidthRst  = 11'd640;
  localparam logic [HeightW-1:0] FrameHeightRst = 13'd480;

  // red in the low byte, blue in the high byte
  typedef logic [PixW-1:0] pixel_t;

  typedef struct packed {
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
    logic             drain;
  } in_t;

  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
    logic             frame_end;
  } out_t;

  // ceil(2^24 / cnt), exact for every sum below 2^12
  function automatic logic [RecipW-1:0] recip_f(input logic [CntW-1:0] cnt);
    logic [RecipW-1:0] r;
    unique case (cnt)
      4'd1:    r = 25'd16777216;
      4'd2:    r = 25'd8388608;
      4'd3:    r = 25'd5592406;
      4'd4:    r = 25'd4194304;
      4'd5:    r = 25'd3355444;
      4'd6:    r = 25'd2796203;
      4'd7:    r = 25'd2396746;
      4'd8:    r = 25'd2097152;
      4'd9:    r = 25'd1864136;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> src/box_blur_3x3_rgb.sv
// top level of the streaming 3x3 rgb box blur
// path: a result passes through the stage 1, stage 2 and output registers after the request that completes its window
// throughput: one request per cycle while the output is not stalled, set by the line store read and the window update
// results trail requests by frame width + 1 positions; width + 1 drain requests flush a frame
// reset: counters, window and pipeline valids clear, width 640 and height 480
// line store contents are undefined after reset and need no clearing pass
module box_blur_3x3_rgb (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bbr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bbr_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  bbr_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output bbr_pkg::out_t                 out_data_o
);

  // configuration registers and their clamped values
  logic [bbr_pkg::WidthW-1:0]  fw_q, fw_d;
  logic [bbr_pkg::HeightW-1:0] fh_q, fh_d;
  logic [bbr_pkg::WidthW-1:0]  w_eff;
  logic [bbr_pkg::HeightW-1:0] h_eff;

  // request and result position counters
  logic [bbr_pkg::ColW-1:0]  col_q, col_d;
  logic [bbr_pkg::RowW-1:0]  row_q, row_d;
  logic [bbr_pkg::ColW-1:0]  ocol_q, ocol_d;
  logic [bbr_pkg::OrowW-1:0] orow_q, orow_d;

  // stage 1: line store read in flight
  logic                      s1_valid_q;
  logic                      s1_emit_q;
  logic                      s1_first_q;
  logic                      s1_fwd_q;
  logic [bbr_pkg::ColW-1:0]  s1_col_q;
  bbr_pkg::pixel_t           s1_pix_q;
  logic [bbr_pkg::LineW-1:0] fwd_data_q;

  // 3 columns x 3 rows, column 0 oldest, row 0 two rows up
  bbr_pkg::pixel_t win_q [9];
  bbr_pkg::pixel_t win_d [9];

  // stage 2: sums and neighbour count
  logic                     s2_valid_q;
  logic                     s2_last_q;
  logic [bbr_pkg::SumW-1:0] s2_sum_q [3];
  logic [bbr_pkg::CntW-1:0] s2_cnt_q;

  // output register
  logic          out_valid_q;
  bbr_pkg::out_t out_data_q;

  // handshake and control
  logic adv;
  logic in_acc;
  logic complete;
  logic ignore;
  logic take;
  logic emit;
  logic step;
  logic s1_last;

  // line store access
  logic [bbr_pkg::LineW-1:0] rd_data;
  logic [bbr_pkg::LineW-1:0] ls;
  logic [bbr_pkg::LineW-1:0] wr_data;

  // window arithmetic
  bbr_pkg::pixel_t          nb [9];
  logic [2:0]               colv;
  logic [2:0]               rowv;
  logic [bbr_pkg::SumW-1:0] sum [3];
  logic [bbr_pkg::CntW-1:0] cnt;
  logic [bbr_pkg::ChanW-1:0] mean [3];

  // out of range sizes clamp: zero acts as one, oversize as the maximum
  always_comb begin
    if (fw_q == '0) begin
      w_eff = bbr_pkg::WidthW'(1);
    end else if (fw_q > bbr_pkg::WidthW'(bbr_pkg::MaxWidth)) begin
      w_eff = bbr_pkg::WidthW'(bbr_pkg::MaxWidth);
    end else begin
      w_eff = fw_q;
    end
    if (fh_q == '0) begin
      h_eff = bbr_pkg::HeightW'(1);
    end else if (fh_q > bbr_pkg::HeightW'(bbr_pkg::MaxHeight)) begin
      h_eff = bbr_pkg::HeightW'(bbr_pkg::MaxHeight);
    end else begin
      h_eff = fh_q;
    end
  end

  // whole pipeline moves when the output register is free or being emptied
  assign adv        = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = ~adv;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // once every pixel of the frame is in, requests count as drains
  assign complete = row_q >= h_eff;
  // a drain before the pixels are complete changes nothing
  assign ignore   = ~complete & in_data_i.drain;
  assign take     = in_acc & ~ignore;
  // position row * width + col reaches width + 1 (col always below width)
  assign emit     = (row_q >= bbr_pkg::RowW'(2))
                  | ((row_q == bbr_pkg::RowW'(1)) & (col_q != '0));
  assign step     = s1_valid_q & adv;

  // same column on consecutive requests: one pixel wide frames and a frame restart
  assign ls      = s1_fwd_q ? fwd_data_q : rd_data;
  assign wr_data = {ls[bbr_pkg::PixW-1:0], s1_pix_q};

  bbr_ram #(
    .Width (bbr_pkg::LineW),
    .Depth (bbr_pkg::MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (step),
    .waddr_i (s1_col_q),
    .wdata_i (wr_data),
    .re_i    (take),
    .raddr_i (col_q),
    .rdata_o (rd_data)
  );

  // configuration writes and position counters
  always_comb begin
    fw_d   = fw_q;
    fh_d   = fh_q;
    col_d  = col_q;
    row_d  = row_q;
    ocol_d = ocol_q;
    orow_d = orow_q;

    if (take) begin
      if (({1'b0, col_q} + bbr_pkg::WidthW'(1)) >= w_eff) begin
        col_d = '0;
        row_d = row_q + bbr_pkg::RowW'(1);
      end else begin
        col_d = col_q + bbr_pkg::ColW'(1);
      end
      // last drain request of the frame: back to the start
      if ({1'b0, row_q} >= ({1'b0, h_eff} + (bbr_pkg::HeightW + 1)'(1))) begin
        col_d = '0;
        row_d = '0;
      end
    end

    if (step & s1_emit_q) begin
      if (({1'b0, ocol_q} + bbr_pkg::WidthW'(1)) >= w_eff) begin
        ocol_d = '0;
        orow_d = orow_q + bbr_pkg::OrowW'(1);
      end else begin
        ocol_d = ocol_q + bbr_pkg::ColW'(1);
      end
      if (s1_last) begin
        ocol_d = '0;
        orow_d = '0;
      end
    end

    // a register write abandons any frame in progress
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        bbr_pkg::RegFrameWidth:  fw_d = cfg_data_i[bbr_pkg::WidthW-1:0];
        bbr_pkg::RegFrameHeight: fh_d = cfg_data_i[bbr_pkg::HeightW-1:0];
        default:                 fw_d = fw_q;
      endcase
      col_d  = '0;
      row_d  = '0;
      ocol_d = '0;
      orow_d = '0;
    end
  end

  // result at the bottom right corner closes the frame
  assign s1_last = (({1'b0, orow_q}) == (h_eff - bbr_pkg::HeightW'(1)))
                 & (({1'b0, ocol_q}) == (w_eff - bbr_pkg::WidthW'(1)));

  // neighbours inside the frame, by column and by row
  assign colv[0] = ocol_q != '0;
  assign colv[1] = 1'b1;
  assign colv[2] = ({1'b0, ocol_q} + bbr_pkg::WidthW'(1)) < w_eff;
  assign rowv[0] = orow_q != '0;
  assign rowv[1] = 1'b1;
  assign rowv[2] = ({1'b0, orow_q} + bbr_pkg::HeightW'(1)) < h_eff;

  // window shift, neighbourhood pick and masked sums
  always_comb begin
    for (int j = 0; j < 6; j++) begin
      win_d[j] = win_q[j + 3];
    end
    win_d[6] = ls[bbr_pkg::LineW-1:bbr_pkg::PixW];
    win_d[7] = ls[bbr_pkg::PixW-1:0];
    win_d[8] = s1_pix_q;

    // at column zero the target is the last pixel of the row before,
    // centred in the newest column of the unshifted window
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        if (s1_first_q) begin
          nb[3 * k + i] = (k == 0) ? win_q[3 + i] : win_q[6 + i];
        end else begin
          nb[3 * k + i] = win_d[3 * k + i];
        end
      end
    end

    cnt = '0;
    for (int c = 0; c < 3; c++) begin
      sum[c] = '0;
    end
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        if (colv[k] & rowv[i]) begin
          cnt = cnt + bbr_pkg::CntW'(1);
          for (int c = 0; c < 3; c++) begin
            sum[c] = sum[c]
                   + bbr_pkg::SumW'(nb[3 * k + i][bbr_pkg::ChanW * c +: bbr_pkg::ChanW]);
          end
        end
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_mean
    bbr_mean u_mean (
      .sum_i  (s2_sum_q[g]),
      .cnt_i  (s2_cnt_q),
      .mean_o (mean[g])
    );
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q        <= bbr_pkg::FrameWidthRst;
      fh_q        <= bbr_pkg::FrameHeightRst;
      col_q       <= '0;
      row_q       <= '0;
      ocol_q      <= '0;
      orow_q      <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < 9; j++) begin
        win_q[j] <= '0;
      end
    end else begin
      fw_q   <= fw_d;
      fh_q   <= fh_d;
      col_q  <= col_d;
      row_q  <= row_d;
      ocol_q <= ocol_d;
      orow_q <= orow_d;
      if (adv) begin
        s1_valid_q  <= take;
        s2_valid_q  <= s1_valid_q & s1_emit_q;
        out_valid_q <= s2_valid_q;
      end
      if (step) begin
        for (int j = 0; j < 9; j++) begin
          win_q[j] <= win_d[j];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_emit_q  <= emit;
      s1_first_q <= col_q == '0;
      s1_col_q   <= col_q;
      // drain requests push a black pixel into the line store
      s1_pix_q   <= complete ? '0
                             : {in_data_i.blue_in, in_data_i.green_in, in_data_i.red_in};
      s1_fwd_q   <= s1_valid_q & (s1_col_q == col_q);
      fwd_data_q <= wr_data;
    end
    if (step) begin
      s2_last_q <= s1_last;
      s2_cnt_q  <= cnt;
      for (int c = 0; c < 3; c++) begin
        s2_sum_q[c] <= sum[c];
      end
    end
    if (adv & s2_valid_q) begin
      out_data_q.red_out   <= mean[0];
      out_data_q.green_out <= mean[1];
      out_data_q.blue_out  <= mean[2];
      out_data_q.frame_end <= s2_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> src/bbr_ram.sv
// generic single-write, single-read ram with registered read data
module bbr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/bbr_mean.sv
// rounded mean of one channel: floor((2*sum + cnt) / (2*cnt)) by reciprocal multiply
module bbr_mean (
  input  logic [bbr_pkg::SumW-1:0]  sum_i,
  input  logic [bbr_pkg::CntW-1:0]  cnt_i,
  output logic [bbr_pkg::ChanW-1:0] mean_o
);

  logic [bbr_pkg::SumW-1:0]                   half_up;
  logic [bbr_pkg::SumW+bbr_pkg::RecipW-1:0]   prod;

  // floor(x / 2c) == floor(floor(x / 2) / c)
  assign half_up = sum_i + bbr_pkg::SumW'(cnt_i >> 1);
  assign prod    = (bbr_pkg::SumW + bbr_pkg::RecipW)'(half_up)
                 * (bbr_pkg::SumW + bbr_pkg::RecipW)'(bbr_pkg::recip_f(cnt_i));
  assign mean_o  = prod[bbr_pkg::RecipShift +: bbr_pkg::ChanW];

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the streaming 3x3 rgb box blur
module testbench;
  import bbr_pkg::*;

  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned QuietLimit   = 5000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned RandomItems  = 440;
  localparam int unsigned ReportLimit  = 10;

  typedef enum int {
    PatRandom,
    PatBlack,
    PatWhite,
    PatExtremes,
    PatNearEdges
  } pattern_e;

  // blur model, its line store and window, and the queue of blurred pixels still due
  class blur_scoreboard;
    logic [LineW-1:0] line_rows [MaxWidth];
    pixel_t           win_px [9];
    int unsigned      width_reg, height_reg;
    int unsigned      in_col, in_row, out_col, out_row;
    out_t             due_pixels [$];
    int unsigned      mismatches, compared;

    function new();
      width_reg  = 32'(FrameWidthRst);
      height_reg = 32'(FrameHeightRst);
      foreach (line_rows[i]) line_rows[i] = '0;
      foreach (win_px[i]) win_px[i] = '0;
      clear_position();
      mismatches = 0;
      compared   = 0;
    endfunction

    function void clear_position();
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MaxWidth) return MaxWidth;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > MaxHeight) return MaxHeight;
      return height_reg;
    endfunction

    // a write abandons the frame in progress but keeps line store and window
    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
      case (idx)
        RegFrameWidth:  width_reg = 32'(value[WidthW-1:0]);
        RegFrameHeight: height_reg = 32'(value[HeightW-1:0]);
        default: ;
      endcase
      clear_position();
    endfunction

    function void take_request(in_t req);
      int unsigned w, h, c, r, cnt;
      int unsigned sum [3];
      bit complete, emit, last;
      pixel_t px, p;
      pixel_t nb [3][3];
      logic [LineW-1:0] held;
      int cx, ry;
      out_t due;
      w = eff_width();
      h = eff_height();
      complete = (in_row >= h);
      // a drain before every pixel of the frame is in is dropped
      if (!complete && req.drain) return;
      px = complete ? '0 : {req.blue_in, req.green_in, req.red_in};
      c = in_col;
      r = in_row;
      emit = (r * w + c) >= w + 1;
      // at column 0 the target is the last pixel of a row, centred in the newest column
      if (emit && c == 0) begin
        for (int i = 0; i < 3; i++) begin
          nb[0][i] = win_px[3 + i];
          nb[1][i] = win_px[6 + i];
          nb[2][i] = win_px[6 + i];
        end
      end
      held = line_rows[c];
      line_rows[c] = {held[PixW-1:0], px};
      for (int i = 0; i < 6; i++) win_px[i] = win_px[i + 3];
      win_px[6] = held[LineW-1:PixW];
      win_px[7] = held[PixW-1:0];
      win_px[8] = px;
      if (emit && c != 0) begin
        for (int k = 0; k < 3; k++)
          for (int i = 0; i < 3; i++) nb[k][i] = win_px[3 * k + i];
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
      if (in_row >= h + 1) begin
        c = 0;
        r = 0;
      end
      in_col = c;
      in_row = r;
      if (!emit) return;

      sum = '{0, 0, 0};
      cnt = 0;
      last = (out_row == h - 1) && (out_col == w - 1);
      for (int dx = 0; dx < 3; dx++) begin
        cx = int'(out_col) + dx - 1;
        if (cx < 0 || cx >= int'(w)) continue;
        for (int dy = 0; dy < 3; dy++) begin
          ry = int'(out_row) + dy - 1;
          if (ry < 0 || ry >= int'(h)) continue;
          p = nb[dx][dy];
          for (int k = 0; k < 3; k++) sum[k] += 32'(p[ChanW*k +: ChanW]);
          cnt++;
        end
      end
      // round half up of sum / count
      due.red_out   = ChanW'((2 * sum[0] + cnt) / (2 * cnt));
      due.green_out = ChanW'((2 * sum[1] + cnt) / (2 * cnt));
      due.blue_out  = ChanW'((2 * sum[2] + cnt) / (2 * cnt));
      due.frame_end = last;
      due_pixels.push_back(due);

      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
      if (last) begin
        out_col = 0;
        out_row = 0;
      end
    endfunction

    function void check_pixel(out_t got);
      out_t want;
      if (due_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("blurred pixel with none due: r %0d g %0d b %0d end %0b",
                   got.red_out, got.green_out, got.blue_out, got.frame_end);
        return;
      end
      want = due_pixels.pop_front();
      compared++;
      if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
          got.blue_out !== want.blue_out || got.frame_end !== want.frame_end) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("pixel %0d: expected r %0d g %0d b %0d end %0b, got r %0d g %0d b %0d end %0b",
                   compared, want.red_out, want.green_out, want.blue_out, want.frame_end,
                   got.red_out, got.green_out, got.blue_out, got.frame_end);
      end
    endfunction
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0]    cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  in_t                in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_t               out_data_o;

  blur_scoreboard sb = new();

  bit          no_idle      = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned requests_sent = 0;
  int unsigned live_requests = 0;
  int unsigned frames_sent   = 0;
  int unsigned writes_done   = 0;

  box_blur_3x3_rgb dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic in_t pixel_of(pattern_e kind);
    in_t req;
    req.drain = 1'b0;
    case (kind)
      PatBlack: begin
        req.red_in = '0; req.green_in = '0; req.blue_in = '0;
      end
      PatWhite: begin
        req.red_in = '1; req.green_in = '1; req.blue_in = '1;
      end
      PatExtremes: begin
        req.red_in   = {ChanW{$urandom_range(0, 1) == 1}};
        req.green_in = {ChanW{$urandom_range(0, 1) == 1}};
        req.blue_in  = {ChanW{$urandom_range(0, 1) == 1}};
      end
      PatNearEdges: begin
        req.red_in   = ChanW'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                   : $urandom_range(252, 255));
        req.green_in = ChanW'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                   : $urandom_range(252, 255));
        req.blue_in  = ChanW'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                   : $urandom_range(252, 255));
      end
      default: begin
        req.red_in   = ChanW'($urandom_range(0, 255));
        req.green_in = ChanW'($urandom_range(0, 255));
        req.blue_in  = ChanW'($urandom_range(0, 255));
      end
    endcase
    return req;
  endfunction

  // valid stays high across back-to-back requests, only lowered for a gap
  task automatic offer_request(input in_t req);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_request(req);
    requests_sent++;
  endtask

  // registers only change once the block has emptied
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.due_pixels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_one(input logic [CfgIdxW-1:0] idx, input int unsigned value);
    logic [CfgW-1:0] data;
    // spare upper bits of a width write carry junk
    data = CfgW'($urandom);
    if (idx == RegFrameWidth) data[WidthW-1:0] = value[WidthW-1:0];
    else data = value[CfgW-1:0];
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    writes_done++;
  endtask

  task automatic set_frame(input bit do_w, input bit do_h,
                           input int unsigned w_raw, input int unsigned h_raw);
    bit width_first;
    width_first = ($urandom_range(0, 1) == 1);
    settle();
    if (do_w && width_first) write_one(RegFrameWidth, w_raw);
    if (do_h) write_one(RegFrameHeight, h_raw);
    if (do_w && !width_first) write_one(RegFrameWidth, w_raw);
    cfg_we_i <= 1'b0;
  endtask

  // whole frame then width+1 flush requests, with optional stray drains and pixel flushes
  task automatic send_frame(input pattern_e kind, input bit noisy);
    int unsigned w, h;
    in_t req;
    w = sb.eff_width();
    h = sb.eff_height();
    for (int unsigned n = 0; n < w * h; n++) begin
      if (noisy && $urandom_range(0, 15) == 0) begin
        req = pixel_of(PatRandom);
        req.drain = 1'b1;
        offer_request(req);
      end
      offer_request(pixel_of(kind));
      live_requests++;
    end
    for (int unsigned n = 0; n <= w; n++) begin
      req = pixel_of(PatRandom);
      req.drain = !(noisy && $urandom_range(0, 2) == 0);
      offer_request(req);
      live_requests++;
    end
    frames_sent++;
  endtask

  // broken frame, cut off by the next register write
  task automatic send_partial(input int unsigned count);
    in_t req;
    for (int unsigned n = 0; n < count; n++) begin
      req = pixel_of(PatRandom);
      req.drain = ($urandom_range(0, 9) == 0);
      offer_request(req);
      live_requests++;
    end
  endtask

  // receiver: per result a random stall, once a long hold-off
  initial begin
    int unsigned hold;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold = HoldCycles;
        hold_request = 1'b0;
      end else begin
        hold = no_idle ? 0 : $urandom_range(0, 10);
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_pixel(out_data_o);
    end
  end

  // watchdog on cycles with no request, result or write
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    in_t         req;
    int unsigned start_count, w_raw, h_raw;
    bit          must_write, pressed, do_w, do_h;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset size, well short of a row and a bit, then abandoned
    send_partial(40);

    // zero registers act as a one pixel frame
    set_frame(1'b1, 1'b1, 0, 0);
    req = pixel_of(PatRandom);
    req.drain = 1'b1;
    offer_request(req);
    offer_request(pixel_of(PatWhite));
    req = pixel_of(PatRandom);
    offer_request(req);
    req.drain = 1'b1;
    offer_request(req);
    frames_sent++;

    set_frame(1'b1, 1'b1, 3, 2);
    send_frame(PatExtremes, 1'b1);
    set_frame(1'b1, 1'b1, 2, 3);
    send_frame(PatWhite, 1'b0);
    send_frame(PatBlack, 1'b0);

    // oversize registers clamp, run as short cut-off frames
    no_idle = 1'b1;
    set_frame(1'b1, 1'b1, 1, 8191);
    send_partial(40);
    no_idle = 1'b0;
    set_frame(1'b1, 1'b1, 2047, 2);
    send_partial(30);

    // random small frames, some cut short, one under a long output hold-off
    start_count = live_requests;
    must_write = 1'b1;
    pressed = 1'b0;
    while (live_requests - start_count < RandomItems) begin
      no_idle = ($urandom_range(0, 5) == 0);
      if (!pressed && live_requests - start_count >= 200) begin
        set_frame(1'b1, 1'b1, 6, 10);
        no_idle = 1'b1;
        hold_request = 1'b1;
        send_frame(PatRandom, 1'b0);
        pressed = 1'b1;
        no_idle = 1'b0;
      end
      if (must_write || $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 7))
          0:       w_raw = 0;
          1:       w_raw = $urandom_range(9, 20);
          default: w_raw = $urandom_range(1, 8);
        endcase
        case ($urandom_range(0, 7))
          0:       h_raw = 0;
          1:       h_raw = $urandom_range(7, 10);
          default: h_raw = $urandom_range(1, 6);
        endcase
        do_w = ($urandom_range(0, 3) != 0);
        do_h = ($urandom_range(0, 3) != 0);
        if (!do_w && !do_h) do_w = 1'b1;
        set_frame(do_w, do_h, w_raw, h_raw);
        must_write = 1'b0;
      end
      if ($urandom_range(0, 7) == 0) begin
        send_partial($urandom_range(1, sb.eff_width() * (sb.eff_height() + 1)));
        must_write = 1'b1;
      end else begin
        send_frame(pattern_e'($urandom_range(0, 4)), ($urandom_range(0, 1) == 1));
      end
    end

    in_valid_i <= 1'b0;
    while (sb.due_pixels.size() != 0) @(posedge clk_i);
    repeat (4 * SettleCycles) @(posedge clk_i);

    $display("%0d requests over %0d frames and %0d register writes, %0d blurred pixels checked",
             requests_sent, frames_sent, writes_done, sb.compared);
    $display("small frames with zero and oversize sizes clamped, one long hold-off, %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.due_pixels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/bbr_pkg.sv
src/bbr_ram.sv
src/bbr_mean.sv
src/box_blur_3x3_rgb.sv
tb/testbench.sv
